// ----- rtl/mnad_pkg.sv -----
// ----------------------------------------------------------------------------
// mnad_pkg
// Shared types and constants for the node announce decoder.
// ----------------------------------------------------------------------------
package mnad_pkg;

  localparam int MaxDepth = 8;
  localparam int LvlW = $clog2(MaxDepth + 1);
  localparam int IdxW = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;

  localparam logic [7:0] TagTrue = 8'hC3;
  localparam logic [7:0] TagU32 = 8'hCE;
  localparam logic [7:0] TagArr16 = 8'hDC;
  localparam logic [31:0] MinElems = 32'd7;
  localparam logic [31:0] NameKey = 32'h01;

  // one accepted byte, as queued between the byte parser and the result stage
  typedef struct packed {
    logic       name_valid;
    logic [7:0] name_byte;
    logic       name_restart;
    logic       last;
    logic       rec_valid;
    logic [31:0] timebase;
    logic [31:0] xfer;
    logic [31:0] sync;
    logic [31:0] cost;
    logic [31:0] flex;
    logic [15:0] name_length;
  } work_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  name_byte;
    logic        name_restart;
    logic        valid_res;
    logic [31:0] timebase;
    logic [31:0] transfer_limit_kb;
    logic [31:0] sync_limit_kb;
    logic [31:0] cost_value;
    logic [31:0] cost_margin;
    logic [15:0] name_length;
    logic        run_end;
  } res_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } item_t;

endpackage

// ----- rtl/mnad_if.sv -----
// ----------------------------------------------------------------------------
// mnad_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface mnad_in_if;
  logic                 valid;
  logic                 ready;
  mnad_pkg::item_t      payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface mnad_out_if;
  logic                 valid;
  logic                 ready;
  mnad_pkg::res_t       payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// ----- rtl/mnad_front.sv -----
// ----------------------------------------------------------------------------
// mnad_front
// Byte parser: walks the msgpack structure one byte per transaction.
// ----------------------------------------------------------------------------
module mnad_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  mnad_pkg::item_t        item,
  output mnad_pkg::work_t        work
);

  localparam logic [3:0] PH_HDR = 4'd0, PH_ELEM0 = 4'd1, PH_TIME = 4'd2,
    PH_ISPN = 4'd3, PH_XFER = 4'd4, PH_SYNC = 4'd5, PH_COSTHDR = 4'd6,
    PH_COST0 = 4'd7, PH_COST1 = 4'd8, PH_COSTX = 4'd9, PH_MAPHDR = 4'd10,
    PH_KEY = 4'd11, PH_VALUE = 4'd12, PH_NAME = 4'd13, PH_HALT = 4'd14;
  localparam logic [2:0] M_TAG = 3'd0, M_COLLECT = 3'd1, M_SKIPTAG = 3'd2,
    M_SKIPRAW = 3'd3, M_SKIPLEN = 3'd4, M_SKIPALEN = 3'd5, M_NAMEBODY = 3'd6;

  logic [3:0]  phase, phase_next;
  logic [2:0]  mode, mode_next;
  logic [16:0] stack [mnad_pkg::MaxDepth];
  // nonzero flag per level lets the settle pop without a search
  logic [mnad_pkg::MaxDepth-1:0] nz, nz_next;
  logic [mnad_pkg::LvlW-1:0] level, level_next;
  logic [16:0] bskip, bskip_next;
  logic [15:0] hshift, hshift_next;
  logic [31:0] acc, acc_next;
  logic [31:0] fs0, fs1, fs2, fs3, fs4, fs0_n, fs1_n, fs2_n, fs3_n, fs4_n;
  logic [15:0] cost_rem, cost_rem_next;
  logic [3:0]  map_rem, map_rem_next;
  logic [15:0] ncount, ncount_next;
  logic        fvalid, fvalid_n, fname, fname_n, frest, frest_n;
  logic        wr_en;
  logic [mnad_pkg::IdxW-1:0] wr_idx;
  logic [16:0] wr_val;
  logic        wr2_en;
  logic [mnad_pkg::IdxW-1:0] wr2_idx;
  logic [16:0] wr2_val;
  logic        emit;
  logic        emit_rest;

  always_comb begin
    logic [7:0]  b;
    logic [31:0] v;
    logic        fin, sk_settle, sk_done, sk_tag, sk_push, sk_raw;
    logic [16:0] push_n, raw_n, top;
    logic [31:0] cnt;
    logic        uint_ok;
    logic [mnad_pkg::LvlW-1:0] lv;
    logic [16:0] bdec;
    logic        nonzero;
    logic [mnad_pkg::MaxDepth-1:0] nzv;
    logic        done;
    b = item.data_byte;
    phase_next = phase; mode_next = mode; nz_next = nz; level_next = level;
    bskip_next = bskip; hshift_next = hshift; acc_next = acc;
    fs0_n = fs0; fs1_n = fs1; fs2_n = fs2; fs3_n = fs3; fs4_n = fs4;
    cost_rem_next = cost_rem; map_rem_next = map_rem; ncount_next = ncount;
    fvalid_n = fvalid; fname_n = fname; frest_n = frest;
    wr_en = 1'b0; wr_idx = '0; wr_val = '0; emit = 1'b0; emit_rest = 1'b0;
    wr2_en = 1'b0; wr2_idx = '0; wr2_val = '0;
    fin = 1'b0; v = '0; sk_settle = 1'b0; sk_done = 1'b0; sk_tag = 1'b0;
    sk_push = 1'b0; sk_raw = 1'b0; push_n = '0; raw_n = '0; cnt = '0;
    uint_ok = 1'b0; lv = level; top = '0; nzv = nz; done = 1'b0;
    bdec = (bskip != '0) ? bskip - 17'd1 : bskip;
    nonzero = 1'b0;

    case (mode)
      M_TAG: begin
        case (phase)
          PH_HDR, PH_COSTHDR: begin
            if (b[7:4] == 4'h9) begin fin = 1'b1; v = {28'd0, b[3:0]}; end
            else if (b == mnad_pkg::TagArr16) begin
              acc_next = '0; bskip_next = 17'd2; mode_next = M_COLLECT;
            end else phase_next = PH_HALT;
          end
          PH_ELEM0, PH_VALUE: begin sk_tag = 1'b1; cnt = 32'd1; end
          PH_TIME, PH_XFER, PH_SYNC, PH_COST0, PH_COST1, PH_KEY: begin
            uint_ok = 1'b1;
            if (b <= 8'h7F) begin fin = 1'b1; v = {24'd0, b}; end
            else if (b == 8'hCC) begin acc_next = '0; bskip_next = 17'd1;
              mode_next = M_COLLECT; end
            else if (b == 8'hCD) begin acc_next = '0; bskip_next = 17'd2;
              mode_next = M_COLLECT; end
            else if (b == mnad_pkg::TagU32) begin acc_next = '0; bskip_next = 17'd4;
              mode_next = M_COLLECT; end
            else uint_ok = 1'b0;
            if (!uint_ok) begin
              if (phase == PH_KEY) begin sk_tag = 1'b1; cnt = 32'd2; end
              else if (phase == PH_COST0 || phase == PH_COST1) begin
                sk_tag = 1'b1; cnt = 32'd1;
              end else phase_next = PH_HALT;
            end
          end
          PH_ISPN: phase_next = (b == mnad_pkg::TagTrue) ? PH_XFER : PH_HALT;
          PH_COSTX: begin sk_tag = 1'b1; cnt = {16'd0, cost_rem}; end
          PH_MAPHDR: begin
            if (b[7:4] == 4'h8 && b[3:0] != 4'd0) begin
              map_rem_next = b[3:0]; phase_next = PH_KEY;
            end else phase_next = PH_HALT;
          end
          PH_NAME: begin
            if (b[7:5] == 3'b101) begin fin = 1'b1; v = {27'd0, b[4:0]}; end
            else if (b == 8'hC4 || b == 8'hD9) begin acc_next = '0;
              bskip_next = 17'd1; mode_next = M_COLLECT; end
            else if (b == 8'hC5) begin acc_next = '0; bskip_next = 17'd2;
              mode_next = M_COLLECT; end
            else begin ncount_next = '0; fname_n = 1'b0; sk_tag = 1'b1;
              cnt = 32'd1; end
          end
          default: ;
        endcase
        if (sk_tag) begin
          // skip_begin: level 1 with count, then tag handling on top
          lv = mnad_pkg::LvlW'(1); top = cnt[16:0]; nzv = '0;
        end
      end
      M_COLLECT: begin
        acc_next = {acc[23:0], b};
        bskip_next = bdec;
        if (bdec == '0) begin fin = 1'b1; v = {acc[23:0], b}; end
      end
      M_SKIPTAG: begin
        sk_tag = 1'b1; top = stack[level[mnad_pkg::IdxW-1:0] - 1'b1];
        if (level == '0) top = '0;
      end
      M_SKIPRAW: begin
        bskip_next = bdec;
        if (bdec == '0) sk_settle = 1'b1;
      end
      M_SKIPLEN, M_SKIPALEN: begin
        hshift_next = {hshift[7:0], b};
        bskip_next = bdec;
        if (bdec == '0) begin
          if (mode == M_SKIPLEN) begin sk_raw = 1'b1; raw_n = {1'b0, hshift[7:0], b}; end
          else begin sk_push = 1'b1; push_n = {1'b0, hshift[7:0], b}; end
        end
      end
      M_NAMEBODY: begin
        emit = 1'b1; emit_rest = frest; frest_n = 1'b0;
        ncount_next = ncount + 16'd1;
        bskip_next = bdec;
        if (bdec == '0) begin fname_n = 1'b1; done = 1'b1; end
      end
      default: phase_next = PH_HALT;
    endcase

    // tag handling while skipping: decrement top, classify
    if (sk_tag) begin
      if (lv == '0) begin phase_next = PH_HALT; mode_next = M_TAG; end
      else begin
        top = top - 17'd1;
        wr_en = 1'b1; wr_idx = mnad_pkg::IdxW'(lv - 1'b1); wr_val = top;
        nzv[mnad_pkg::IdxW'(lv - 1'b1)] = (top != '0);
        level_next = lv; mode_next = M_SKIPTAG; nz_next = nzv;
        if (b <= 8'h7F || b >= 8'hE0 || b == 8'hC0 || b == 8'hC2 || b == 8'hC3)
          sk_settle = 1'b1;
        else if (b[7:4] == 4'h8) begin sk_push = 1'b1; push_n = {12'd0, b[3:0], 1'b0}; end
        else if (b[7:4] == 4'h9) begin sk_push = 1'b1; push_n = {13'd0, b[3:0]}; end
        else if (b[7:5] == 3'b101) begin sk_raw = 1'b1; raw_n = {12'd0, b[4:0]}; end
        else begin
          case (b)
            8'hC4, 8'hD9: begin hshift_next = '0; bskip_next = 17'd1; mode_next = M_SKIPLEN; end
            8'hC5, 8'hDA: begin hshift_next = '0; bskip_next = 17'd2; mode_next = M_SKIPLEN; end
            mnad_pkg::TagArr16: begin hshift_next = '0; bskip_next = 17'd2;
              mode_next = M_SKIPALEN; end
            8'hCC, 8'hD0: begin sk_raw = 1'b1; raw_n = 17'd1; end
            8'hCD, 8'hD1: begin sk_raw = 1'b1; raw_n = 17'd2; end
            8'hCA, 8'hCE, 8'hD2: begin sk_raw = 1'b1; raw_n = 17'd4; end
            8'hCB, 8'hCF, 8'hD3: begin sk_raw = 1'b1; raw_n = 17'd8; end
            default: begin phase_next = PH_HALT; mode_next = M_TAG; end
          endcase
        end
      end
    end

    if (sk_raw) begin
      if (raw_n == '0) sk_settle = 1'b1;
      else begin bskip_next = raw_n; mode_next = M_SKIPRAW; end
    end
    if (sk_push) begin
      if (push_n == '0) sk_settle = 1'b1;
      else if (int'(level_next) >= mnad_pkg::MaxDepth) begin
        phase_next = PH_HALT; mode_next = M_TAG;
      end else begin
        wr2_en = 1'b1; wr2_idx = mnad_pkg::IdxW'(level_next); wr2_val = push_n;
        nz_next[mnad_pkg::IdxW'(level_next)] = 1'b1;
        level_next = level_next + 1'b1; mode_next = M_SKIPTAG;
      end
    end
    if (sk_settle) begin
      // pop to the highest level that still has a nonzero count
      lv = '0;
      for (int i = 0; i < mnad_pkg::MaxDepth; i++)
        if (nz_next[i] && i < int'(level_next)) lv = mnad_pkg::LvlW'(i + 1);
      level_next = lv;
      if (lv == '0) sk_done = 1'b1; else mode_next = M_SKIPTAG;
    end
    if (sk_done) begin
      mode_next = M_TAG;
      case (phase)
        PH_ELEM0: phase_next = PH_TIME;
        PH_COST0: begin fs3_n = '0; phase_next = PH_COST1; end
        PH_COST1: begin fs4_n = '0; phase_next = (cost_rem != '0) ? PH_COSTX : PH_MAPHDR; end
        PH_COSTX: phase_next = PH_MAPHDR;
        PH_KEY, PH_VALUE, PH_NAME: done = 1'b1;
        default: phase_next = PH_HALT;
      endcase
    end
    if (fin) begin
      mode_next = M_TAG;
      case (phase)
        PH_HDR: phase_next = (v < mnad_pkg::MinElems) ? PH_HALT : PH_ELEM0;
        PH_TIME: begin fs0_n = v; phase_next = PH_ISPN; end
        PH_XFER: begin fs1_n = v; phase_next = PH_SYNC; end
        PH_SYNC: begin fs2_n = v; phase_next = PH_COSTHDR; end
        PH_COSTHDR: begin
          if (v < 32'd2) phase_next = PH_HALT;
          else begin fvalid_n = 1'b1; cost_rem_next = 16'(v - 32'd2);
            phase_next = PH_COST0; end
        end
        PH_COST0: begin fs3_n = v; phase_next = PH_COST1; end
        PH_COST1: begin fs4_n = v;
          phase_next = (cost_rem != '0) ? PH_COSTX : PH_MAPHDR; end
        PH_KEY: phase_next = (v == mnad_pkg::NameKey) ? PH_NAME : PH_VALUE;
        PH_NAME: begin
          ncount_next = '0; fname_n = 1'b0; frest_n = 1'b1;
          if (v == '0) begin fname_n = 1'b1; done = 1'b1; end
          else begin bskip_next = {1'b0, v[15:0]}; mode_next = M_NAMEBODY; end
        end
        default: phase_next = PH_HALT;
      endcase
    end
    if (done) begin
      mode_next = M_TAG;
      map_rem_next = map_rem - 4'd1;
      phase_next = (map_rem - 4'd1 == 4'd0) ? PH_HALT : PH_KEY;
    end
    nonzero = |nz_next;
    if (!nonzero) nz_next = nz_next;
  end

  // a push and the decrement of the level below land on different entries
  always_ff @(posedge clk) begin
    for (int i = 0; i < mnad_pkg::MaxDepth; i++) begin
      if (take && wr2_en && int'(wr2_idx) == i) stack[i] <= wr2_val;
      else if (take && wr_en && int'(wr_idx) == i) stack[i] <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && item.is_last)) begin
      phase <= PH_HDR; mode <= M_TAG; nz <= '0; level <= '0; bskip <= '0;
      hshift <= '0; acc <= '0; fs0 <= '0; fs1 <= '0; fs2 <= '0; fs3 <= '0;
      fs4 <= '0; cost_rem <= '0; map_rem <= '0; ncount <= '0;
      fvalid <= 1'b0; fname <= 1'b0; frest <= 1'b0;
    end else if (take) begin
      phase <= phase_next; mode <= mode_next; nz <= nz_next; level <= level_next;
      bskip <= bskip_next; hshift <= hshift_next; acc <= acc_next;
      fs0 <= fs0_n; fs1 <= fs1_n; fs2 <= fs2_n; fs3 <= fs3_n; fs4 <= fs4_n;
      cost_rem <= cost_rem_next; map_rem <= map_rem_next; ncount <= ncount_next;
      fvalid <= fvalid_n; fname <= fname_n; frest <= frest_n;
    end
  end

  always_comb begin
    work.name_valid = emit;
    work.name_byte = item.data_byte;
    work.name_restart = emit_rest;
    work.last = item.is_last;
    work.rec_valid = fvalid_n;
    work.timebase = fs0_n;
    work.xfer = fs1_n;
    work.sync = fs2_n;
    work.cost = fs3_n;
    work.flex = fs4_n;
    work.name_length = fname_n ? ncount_next : 16'd0;
  end

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    int'(level) <= mnad_pkg::MaxDepth) else $error("stack level overflow");
  a_halt_tag: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HALT |-> mode == M_TAG) else $error("halt with busy mode");
  a_skip_level: assert property (@(posedge clk) disable iff (rst)
    mode == M_SKIPTAG |-> level != '0) else $error("skip with empty stack");

endmodule

// ----- rtl/mnad_queue.sv -----
// ----------------------------------------------------------------------------
// mnad_queue
// Two-entry queue between the parser and the result stage.
// ----------------------------------------------------------------------------
module mnad_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mnad_pkg::work_t  din,
  output logic             full,
  output logic             nempty,
  input  logic             pop,
  output mnad_pkg::work_t  dout
);

  mnad_pkg::work_t mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign full = (cnt == 2'd2);
  assign nempty = (cnt != 2'd0);
  assign dout = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(push && full)) else $error("queue overrun");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    !(pop && !nempty)) else $error("queue underrun");
  a_cnt_ok: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3) else $error("queue count corrupt");

endmodule

// ----- rtl/mnad_back.sv -----
// ----------------------------------------------------------------------------
// mnad_back
// Result stage: turns one queued byte record into zero, one or two results.
// ----------------------------------------------------------------------------
module mnad_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             nempty,
  input  mnad_pkg::work_t  w,
  output logic             pop,
  mnad_out_if.source       res
);

  // second: the name byte of this record has gone, record end is next
  logic second;
  logic has_name, has_end, is_fin, fire;

  assign has_name = w.name_valid && !second;
  assign has_end = w.last;
  assign is_fin = !has_name || !has_end;
  assign fire = res.valid && res.ready;
  assign res.valid = nempty && (has_name || has_end);
  assign pop = nempty && (!(has_name || has_end) || (fire && is_fin));

  always_comb begin
    res.payload = '0;
    if (has_name) begin
      res.payload.name_byte = w.name_byte;
      res.payload.name_restart = w.name_restart;
    end else begin
      res.payload.kind = 1'b1;
      if (w.rec_valid) begin
        res.payload.valid_res = 1'b1;
        res.payload.timebase = w.timebase;
        res.payload.transfer_limit_kb = w.xfer;
        res.payload.sync_limit_kb = w.sync;
        res.payload.cost_value = w.cost;
        res.payload.cost_margin = w.flex;
        res.payload.name_length = w.name_length;
      end
    end
    res.payload.run_end = is_fin;
  end

  always_ff @(posedge clk) begin
    if (rst) second <= 1'b0;
    else if (pop) second <= 1'b0;
    else if (fire) second <= 1'b1;
  end

  a_second_end: assert property (@(posedge clk) disable iff (rst)
    second |-> (nempty && w.last)) else $error("second result without end");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid) else $error("result dropped");

endmodule

// ----- rtl/msgpack_node_announce_decoder.sv -----
// ----------------------------------------------------------------------------
// msgpack_node_announce_decoder
// Streaming decoder of a node announce payload, one byte per transaction.
// ----------------------------------------------------------------------------
// The queue registers each accepted byte record before the result stage.
// Throughput: one byte per cycle unless the queue is full; a byte ending
//   the record with a pending name byte: two results in the result stage.
// The two-entry queue decouples the parser from output stalls.
// Reset: synchronous rst returns the parser to expect the outer array header.
module msgpack_node_announce_decoder (
  input  logic      clk,
  input  logic      rst,
  mnad_in_if.sink   in_ch,
  mnad_out_if.source out_ch
);

  logic            take, full, nempty, pop;
  mnad_pkg::work_t w_in, w_out;

  assign in_ch.ready = !full;
  assign take = in_ch.valid && in_ch.ready;

  mnad_front u_front (.clk, .rst, .take, .item(in_ch.payload), .work(w_in));
  mnad_queue u_queue (.clk, .rst, .push(take), .din(w_in), .full, .nempty,
    .pop, .dout(w_out));
  mnad_back u_back (.clk, .rst, .nempty, .w(w_out), .pop, .res(out_ch));

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks the node announce decoder against a byte-level predictor of the
// msgpack parse, using well-formed announces with random content, broken
// announces and random noise, under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int Depth = mnad_pkg::MaxDepth;
  localparam int CycleLimit = 400000;

  typedef enum int {
    PhHdr, PhElem0, PhTime, PhIspn, PhXfer, PhSync, PhCostHdr, PhCost0, PhCost1,
    PhCostX, PhMapHdr, PhKey, PhValue, PhName, PhHalt
  } phase_e;
  typedef enum int {
    MdTag, MdCollect, MdSkipTag, MdSkipRaw, MdSkipLen, MdSkipALen, MdNameBody
  } mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mnad_in_if  in_ch();
  mnad_out_if out_ch();

  msgpack_node_announce_decoder dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // decoder state mirror
  phase_e      ph;
  mode_e       md;
  logic [16:0] stk [Depth];
  int unsigned lvl;
  logic [16:0] remain;
  logic [15:0] hshift;
  logic [31:0] acc;
  logic [31:0] fld [5];
  logic [15:0] cost_left;
  logic [3:0]  map_left;
  logic [15:0] name_cnt;
  bit          rec_ok, name_ok, restart_pend;

  mnad_pkg::item_t pending_bytes[$];
  mnad_pkg::res_t  expected_results[$];
  int    errors = 0;
  int    sent = 0;
  bit    stim_done = 0;
  int    cycles = 0;

  function automatic void decoder_clear();
    ph = PhHdr; md = MdTag; lvl = 0; remain = '0; hshift = '0; acc = '0;
    for (int i = 0; i < 5; i++) fld[i] = '0;
    for (int i = 0; i < Depth; i++) stk[i] = '0;
    cost_left = '0; map_left = '0; name_cnt = '0;
    rec_ok = 0; name_ok = 0; restart_pend = 0;
  endfunction

  function automatic void go(phase_e p);
    ph = p; md = MdTag;
  endfunction

  function automatic void entry_done();
    map_left = map_left - 4'd1;
    if (map_left == 0) go(PhHalt); else go(PhKey);
  endfunction

  function automatic void after_costs();
    if (cost_left != 0) go(PhCostX); else go(PhMapHdr);
  endfunction

  function automatic void skip_done();
    case (ph)
      PhElem0: go(PhTime);
      PhCost0: begin fld[3] = '0; go(PhCost1); end
      PhCost1: begin fld[4] = '0; after_costs(); end
      PhCostX: go(PhMapHdr);
      PhKey, PhValue, PhName: entry_done();
      default: go(PhHalt);
    endcase
  endfunction

  function automatic void skip_settle();
    while (lvl > 0 && stk[lvl-1] == 0) lvl--;
    if (lvl == 0) skip_done(); else md = MdSkipTag;
  endfunction

  function automatic void skip_push(int unsigned n);
    if (n == 0) begin skip_settle(); return; end
    if (lvl >= Depth) begin go(PhHalt); return; end
    stk[lvl] = n[16:0]; lvl++; md = MdSkipTag;
  endfunction

  function automatic void skip_raw(int unsigned n);
    if (n == 0) begin skip_settle(); return; end
    remain = n[16:0]; md = MdSkipRaw;
  endfunction

  function automatic void skip_tag(logic [7:0] b);
    if (lvl == 0 || lvl > Depth) begin go(PhHalt); return; end
    stk[lvl-1] = stk[lvl-1] - 17'd1;
    if (b <= 8'h7F || b >= 8'hE0 || b == 8'hC0 || b == 8'hC2 || b == mnad_pkg::TagTrue)
      skip_settle();
    else if (b[7:4] == 4'h8) skip_push(b[3:0] * 2);
    else if (b[7:4] == 4'h9) skip_push(b[3:0]);
    else if (b[7:5] == 3'b101) skip_raw(b[4:0]);
    else case (b)
      8'hC4, 8'hD9: begin hshift = '0; remain = 17'd1; md = MdSkipLen; end
      8'hC5, 8'hDA: begin hshift = '0; remain = 17'd2; md = MdSkipLen; end
      mnad_pkg::TagArr16: begin hshift = '0; remain = 17'd2; md = MdSkipALen; end
      8'hCC, 8'hD0: skip_raw(1);
      8'hCD, 8'hD1: skip_raw(2);
      8'hCA, mnad_pkg::TagU32, 8'hD2: skip_raw(4);
      8'hCB, 8'hCF, 8'hD3: skip_raw(8);
      default: go(PhHalt);
    endcase
  endfunction

  function automatic void skip_begin(int unsigned cnt, logic [7:0] b);
    lvl = 1; stk[0] = cnt[16:0]; md = MdSkipTag;
    skip_tag(b);
  endfunction

  function automatic void name_begin(logic [31:0] len);
    name_cnt = '0; name_ok = 0; restart_pend = 1;
    if (len == 0) begin name_ok = 1; entry_done(); end
    else begin remain = {1'b0, len[15:0]}; md = MdNameBody; end
  endfunction

  function automatic void finish_value(logic [31:0] v);
    case (ph)
      PhHdr: if (v < mnad_pkg::MinElems) go(PhHalt); else go(PhElem0);
      PhTime: begin fld[0] = v; go(PhIspn); end
      PhXfer: begin fld[1] = v; go(PhSync); end
      PhSync: begin fld[2] = v; go(PhCostHdr); end
      PhCostHdr: begin
        if (v < 32'd2) go(PhHalt);
        else begin rec_ok = 1; cost_left = 16'(v - 32'd2); go(PhCost0); end
      end
      PhCost0: begin fld[3] = v; go(PhCost1); end
      PhCost1: begin fld[4] = v; after_costs(); end
      PhKey: if (v == mnad_pkg::NameKey) go(PhName); else go(PhValue);
      PhName: name_begin(v);
      default: go(PhHalt);
    endcase
  endfunction

  function automatic void collect(int unsigned n);
    acc = '0; remain = n[16:0]; md = MdCollect;
  endfunction

  function automatic bit uint_tag(logic [7:0] b);
    if (b <= 8'h7F) begin finish_value({24'd0, b}); return 1; end
    if (b == 8'hCC) begin collect(1); return 1; end
    if (b == 8'hCD) begin collect(2); return 1; end
    if (b == mnad_pkg::TagU32) begin collect(4); return 1; end
    return 0;
  endfunction

  function automatic bit count_down();
    if (remain != 0) remain--;
    return remain == 0;
  endfunction

  // advance the mirror by one byte and queue the results it causes
  function automatic void decode_byte(mnad_pkg::item_t it);
    logic [7:0] b;
    mnad_pkg::res_t r;
    bit got_name;
    b = it.data_byte;
    got_name = 0;
    r = '0;
    case (md)
      MdTag: begin
        case (ph)
          PhHdr, PhCostHdr: begin
            if (b[7:4] == 4'h9) finish_value({28'd0, b[3:0]});
            else if (b == mnad_pkg::TagArr16) collect(2);
            else go(PhHalt);
          end
          PhElem0, PhValue: skip_begin(1, b);
          PhTime, PhXfer, PhSync: if (!uint_tag(b)) go(PhHalt);
          PhIspn: if (b == mnad_pkg::TagTrue) go(PhXfer); else go(PhHalt);
          PhCost0, PhCost1: if (!uint_tag(b)) skip_begin(1, b);
          PhCostX: skip_begin(cost_left, b);
          PhMapHdr: begin
            if (b[7:4] == 4'h8 && b[3:0] != 0) begin map_left = b[3:0]; go(PhKey); end
            else go(PhHalt);
          end
          PhKey: if (!uint_tag(b)) skip_begin(2, b);
          PhName: begin
            if (b[7:5] == 3'b101) name_begin({27'd0, b[4:0]});
            else if (b == 8'hC4 || b == 8'hD9) collect(1);
            else if (b == 8'hC5) collect(2);
            else begin name_cnt = '0; name_ok = 0; skip_begin(1, b); end
          end
          default: ;
        endcase
      end
      MdCollect: begin
        acc = {acc[23:0], b};
        if (count_down()) finish_value(acc);
      end
      MdSkipTag: skip_tag(b);
      MdSkipRaw: if (count_down()) skip_settle();
      MdSkipLen: begin
        hshift = {hshift[7:0], b};
        if (count_down()) skip_raw(hshift);
      end
      MdSkipALen: begin
        hshift = {hshift[7:0], b};
        if (count_down()) skip_push(hshift);
      end
      MdNameBody: begin
        got_name = 1;
        r.name_byte = b;
        r.name_restart = restart_pend;
        restart_pend = 0;
        name_cnt = name_cnt + 16'd1;
        if (count_down()) begin name_ok = 1; entry_done(); end
      end
      default: go(PhHalt);
    endcase
    if (got_name) begin
      r.run_end = !it.is_last;
      expected_results = {expected_results, r};
    end
    if (it.is_last) begin
      r = '0;
      r.kind = 1'b1;
      r.run_end = 1'b1;
      if (rec_ok) begin
        r.valid_res = 1'b1;
        r.timebase = fld[0];
        r.transfer_limit_kb = fld[1];
        r.sync_limit_kb = fld[2];
        r.cost_value = fld[3];
        r.cost_margin = fld[4];
        r.name_length = name_ok ? name_cnt : 16'd0;
      end
      expected_results = {expected_results, r};
      decoder_clear();
    end
  endfunction

  // ---------------- stimulus builders ----------------
  logic [7:0] msg[$];

  function automatic void add_byte(logic [7:0] v);
    msg = {msg, v};
  endfunction

  function automatic void put_uint(int unsigned v, int unsigned form);
    case (form)
      0: add_byte({1'b0, v[6:0]});
      1: begin add_byte(8'hCC); add_byte(v[7:0]); end
      2: begin add_byte(8'hCD); add_byte(v[15:8]); add_byte(v[7:0]); end
      default: begin
        add_byte(mnad_pkg::TagU32);
        add_byte(v[31:24]); add_byte(v[23:16]);
        add_byte(v[15:8]); add_byte(v[7:0]);
      end
    endcase
  endfunction

  function automatic void put_rand_uint();
    put_uint($urandom, $urandom_range(0, 3));
  endfunction

  // a random element that can be skipped, nested up to lv levels
  function automatic void put_any(int lv);
    int unsigned k, n;
    k = $urandom_range(0, (lv > 0) ? 9 : 7);
    case (k)
      0: add_byte(8'($urandom_range(0, 127)));
      1: add_byte(8'($urandom_range(224, 255)));
      2: add_byte(8'(8'hC0 | ($urandom_range(0, 1) << 1) | $urandom_range(0, 1) * 3));
      3: put_rand_uint();
      4: begin
        n = $urandom_range(0, 4);
        add_byte(8'hA0 | {3'd0, n[4:0]});
        repeat (n) add_byte(8'($urandom));
      end
      5: begin
        n = $urandom_range(0, 3);
        add_byte($urandom_range(0, 1) ? 8'hC4 : 8'hD9);
        add_byte(n[7:0]);
        repeat (n) add_byte(8'($urandom));
      end
      6: begin
        add_byte(8'hD3);
        repeat (8) add_byte(8'($urandom));
      end
      7: begin
        add_byte(8'hDA); add_byte(8'h00); add_byte(8'h01);
        add_byte(8'($urandom));
      end
      8: begin
        n = $urandom_range(0, 3);
        add_byte(8'h90 | {4'd0, n[3:0]});
        repeat (n) put_any(lv - 1);
      end
      default: begin
        n = $urandom_range(0, 2);
        if ($urandom_range(0, 1)) begin
          add_byte(mnad_pkg::TagArr16); add_byte(8'h00); add_byte(n[7:0]);
          repeat (n) put_any(lv - 1);
        end else begin
          add_byte(8'h80 | {4'd0, n[3:0]});
          repeat (2 * n) put_any(lv - 1);
        end
      end
    endcase
  endfunction

  function automatic void put_name();
    int unsigned n, k;
    k = $urandom_range(0, 9);
    n = (k == 9) ? $urandom_range(32, 60) : $urandom_range(0, 12);
    if (n < 32 && $urandom_range(0, 2) != 0) add_byte(8'hA0 | {3'd0, n[4:0]});
    else if ($urandom_range(0, 1)) begin add_byte(8'hC4); add_byte(n[7:0]); end
    else begin add_byte(8'hC5); add_byte(8'h00); add_byte(n[7:0]); end
    repeat (n) add_byte(8'($urandom));
  endfunction

  function automatic void build_announce();
    int unsigned nel, ncost, nmap;
    nel = $urandom_range(7, 9);
    if ($urandom_range(0, 3) == 0) begin
      add_byte(mnad_pkg::TagArr16); add_byte(8'h00); add_byte(nel[7:0]);
    end else add_byte(8'h90 | {4'd0, nel[3:0]});
    put_any(2);
    put_rand_uint();
    add_byte(mnad_pkg::TagTrue);
    put_rand_uint();
    put_rand_uint();
    ncost = $urandom_range(2, 4);
    add_byte(8'h90 | {4'd0, ncost[3:0]});
    repeat (ncost) if ($urandom_range(0, 3) == 0) put_any(1); else put_rand_uint();
    nmap = $urandom_range(1, 4);
    add_byte(8'h80 | {4'd0, nmap[3:0]});
    repeat (nmap) begin
      case ($urandom_range(0, 5))
        0, 1, 2: begin add_byte(8'h01); put_name(); end
        3: begin put_rand_uint(); put_any(2); end
        4: begin add_byte(8'h01); put_any(1); end
        default: begin put_any(1); put_any(1); end
      endcase
    end
    repeat (nel - 7) put_any(1);
  endfunction

  function automatic void send_msg();
    mnad_pkg::item_t it;
    foreach (msg[i]) begin
      it.data_byte = msg[i];
      it.is_last = (i == msg.size() - 1);
      pending_bytes = {pending_bytes, it};
      sent++;
    end
    msg.delete();
  endfunction

  // deep nest to overflow the count stack
  function automatic void build_overflow();
    msg = {8'h97, 8'h91};
    repeat (Depth + 1) add_byte(8'h91);
    add_byte(8'h01);
  endfunction

  initial begin
    int unsigned k, cut;
    decoder_clear();
    // directed: full-width values, two-byte name, non-uint cost and key
    msg = {8'h97, 8'h00, mnad_pkg::TagU32, 8'hFF, 8'hFF, 8'hFF, 8'hFF, mnad_pkg::TagTrue,
           mnad_pkg::TagU32, 8'h00, 8'h00, 8'h00, 8'h00, 8'hCD, 8'hFF, 8'hFF,
           8'h92, 8'hA1, 8'h41, 8'hCC, 8'hFF,
           8'h82, 8'hA1, 8'h78, 8'h05, 8'h01, 8'hA2, 8'h4E, 8'h31};
    send_msg();
    msg = {8'h96, 8'h00}; send_msg();                        // too few elements
    msg = {8'h97, 8'hC1, 8'h00}; send_msg();                 // unknown tag in element 0
    msg = {8'h97, 8'h00, 8'h05, 8'hC2}; send_msg();          // flag false
    msg = {8'h97, 8'h00, 8'h05, mnad_pkg::TagTrue, 8'h01, 8'h02, 8'h91, 8'h00}; send_msg();
    msg = {8'h97, 8'h00, 8'h05, mnad_pkg::TagTrue, 8'h01, 8'h02, 8'h92, 8'h03, 8'h04,
           8'h90}; send_msg();                               // metadata not a fixmap
    msg = {8'h97, 8'h00, 8'h05, mnad_pkg::TagTrue, 8'h01, 8'h02, 8'h92, 8'h03, 8'h04,
           8'h81, 8'h01, 8'hA5, 8'h41}; send_msg();          // truncated name
    msg = {8'h97, 8'h00, 8'h05, mnad_pkg::TagTrue, 8'h01, 8'h02, 8'h92, 8'h03, 8'h04,
           8'h82, 8'h01, 8'hA1, 8'h5A, 8'h01, 8'hC0, 8'hFF, 8'hEE}; send_msg();
    build_overflow(); send_msg();
    msg = {8'hFF}; send_msg();
    // random part
    while (sent < 1100) begin
      k = $urandom_range(0, 9);
      if (k < 7) build_announce();
      else if (k < 9) begin
        build_announce();
        cut = $urandom_range(1, msg.size());
        while (msg.size() > cut) void'(msg.pop_back());
        if ($urandom_range(0, 1)) msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom);
      end else repeat ($urandom_range(1, 20)) add_byte(8'($urandom));
      send_msg();
    end
    stim_done = 1;
  end

  // ---------------- driver ----------------
  int unsigned burst_left = 0, gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.payload <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) decode_byte(in_ch.payload);
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.payload <= pending_bytes.pop_front();
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
          end else burst_left--;
        end else in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------- monitor and sink ----------------
  int unsigned hold_off = 0;
  bit long_done = 0;

  always @(posedge clk) begin
    mnad_pkg::res_t got, want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %h actual %h", want, got);
          end
        end
      end
      // hold off for a long stretch once, while input is still streaming
      if (!long_done && cycles == 400) begin
        hold_off = 300; long_done = 1;
      end
      if (hold_off > 0) begin
        hold_off--;
        out_ch.ready <= 1'b0;
      end else if (cycles % 2000 < 500) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    @(negedge rst);
    wait (stim_done && pending_bytes.size() == 0 && !in_ch.valid);
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
